@@ hw/rtl/lfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfpd_pkg
// shared widths and constants of the line follower pd drive block
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  // field widths
  localparam int SENS_W = 10;
  localparam int SPD_W  = 9;
  localparam int TIME_W = 32;
  localparam int ERR_W  = 12;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // centroid divider widths
  localparam int NUM_W = 24;              // weighted sum, up to 10,000,000
  localparam int SUM_W = 13;              // sensor sum, up to 5000
  localparam int POS_W = 12;              // position, 0..4000
  localparam int CNT_W = $clog2(NUM_W);
  localparam int WSUM_W = 14;             // weight index sum, up to 10000

  // register indexes (byte address bit 2)
  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  localparam logic [SENS_W-1:0] SENS_MAX = 10'd1000;
  localparam logic [NUM_W-1:0]  WEIGHT   = 24'd1000;
  localparam logic [POS_W-1:0]  CENTER_POS = 12'd2000;

  localparam logic [TIME_W-1:0]      RAMP_PERIOD = 32'd3;
  localparam logic signed [SPD_W:0]  RAMP_STEP   = 10'sd3;
  localparam logic signed [SPD_W-1:0] SPD_RESET  = 9'sd50;
  localparam logic signed [SPD_W-1:0] SPD_HI     = 9'sd150;
  localparam logic signed [SPD_W-1:0] SPD_MID    = 9'sd100;
  localparam logic signed [SPD_W-1:0] DRIVE_MAX  = 9'sd250;
  localparam logic signed [SPD_W-1:0] DRIVE_MIN  = -9'sd250;

  // reciprocals scaled by 2^16, exact for the magnitudes that occur
  localparam int RECIP_SH = 16;
  localparam logic [RECIP_SH-1:0] RECIP_10 = 16'd6554;
  localparam logic [RECIP_SH-1:0] RECIP_25 = 16'd2622;
  localparam logic [RECIP_SH-1:0] RECIP_3  = 16'd21846;

endpackage

`default_nettype wire

@@ hw/rtl/lfpd_div.sv @@
// ----------------------------------------------------------------------------
// lfpd_div
// restoring divider for the line centroid, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_div (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire  [lfpd_pkg::NUM_W-1:0]      dividend,
  input  wire  [lfpd_pkg::SUM_W-1:0]      divisor,
  output logic                            done,
  output logic [lfpd_pkg::POS_W-1:0]      quotient
);
  import lfpd_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] dvd;
  logic [SUM_W-1:0] dsr;
  logic [SUM_W-1:0] rem;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, dvd[NUM_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient fits in POS_W bits, upper bits shift out as zeros
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[NUM_W-2:0], 1'b0};
      rem      <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quotient <= {quotient[POS_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/line_follow_pd_drive.sv @@
// ----------------------------------------------------------------------------
// line_follow_pd_drive
// pd steering for a line follower: one sensor frame in, two wheel drives out
// ----------------------------------------------------------------------------
// Each input word is a timestamp and five reflectance samples. The block
// takes one word at a time: the input stalls from the word being taken
// until its result is offered, and the next input word can be taken in the
// cycle the result is first offered. Most of the time is the line centroid,
// found by a restoring divider that produces one quotient bit per cycle;
// the load, the wait for the divider, the pd law and the saturation take
// the rest. A finished word sits in the output register while the next
// frame is taken; if that word is still stalled when the next result is
// ready, the new result waits in the controller and the input stalls until
// it leaves.
// Registers: target_speed at byte address 0, window_mode at byte address 4.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_pd_drive (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [lfpd_pkg::ADDR_W-1:0]           paddr,
  input  wire  [lfpd_pkg::DATA_W-1:0]           pwdata,
  output logic [lfpd_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  // sensor frames
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [lfpd_pkg::TIME_W-1:0]           time_ms,
  input  wire  [lfpd_pkg::SENS_W-1:0]           sensor_a,
  input  wire  [lfpd_pkg::SENS_W-1:0]           sensor_b,
  input  wire  [lfpd_pkg::SENS_W-1:0]           sensor_c,
  input  wire  [lfpd_pkg::SENS_W-1:0]           sensor_d,
  input  wire  [lfpd_pkg::SENS_W-1:0]           sensor_e,
  // drive commands
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [lfpd_pkg::SPD_W-1:0]     left_drive,
  output logic signed [lfpd_pkg::SPD_W-1:0]     right_drive,
  output logic                                  no_line
);
  import lfpd_pkg::*;

  localparam int CORR_W = 16;
  localparam int D_W    = ERR_W + 1;
  localparam int PE_W   = ERR_W + RECIP_SH;
  localparam int PD_W   = D_W + RECIP_SH;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_DIV, S_PD1, S_PD2, S_PD3, S_OUT
  } state_t;

  state_t state;

  // configuration and state
  logic signed [SPD_W-1:0] tgt;
  logic                    window;
  logic signed [SPD_W-1:0] cur_speed;
  logic [TIME_W-1:0]       last_ramp;
  logic signed [ERR_W-1:0] prev_err;

  // frame registers
  logic [TIME_W-1:0] t_in;
  logic [SENS_W-1:0] s_a, s_b, s_c, s_d, s_e;
  logic              nl_r;
  logic signed [D_W-1:0]    err_r;
  logic signed [D_W-1:0]    d_r;
  logic signed [ERR_W-1:0]  e_div;
  logic signed [D_W-1:0]    d_div;
  logic signed [CORR_W-1:0] corr;

  // divider interface
  logic             div_start;
  logic             div_done;
  logic [POS_W-1:0] div_quo;

  logic [WSUM_W-1:0] wsum;
  logic [NUM_W-1:0]  num;
  logic [SUM_W-1:0]  sum;

  logic [TIME_W-1:0]       tdiff;
  logic signed [SPD_W:0]   spd_delta;
  logic signed [SPD_W:0]   spd_step;
  logic signed [SPD_W-1:0] cur_speed_next;

  logic [POS_W-1:0]        pos;
  logic signed [D_W-1:0]   err;
  logic signed [D_W-1:0]   dval;

  logic [ERR_W-1:0]    err_abs;
  logic [D_W-1:0]      d_abs;
  logic [RECIP_SH-1:0] recip_e;
  logic [PE_W-1:0]     pe;
  logic [PD_W-1:0]     pd;

  logic signed [CORR_W-1:0] e16, d16, dd16, d5, fh;
  logic signed [CORR_W-1:0] spd16, lsum, rsum;
  logic signed [SPD_W-1:0]  left_next, right_next;

  logic cfg_wr;
  logic accept;
  logic out_free;

  function automatic logic [SENS_W-1:0] sat(input logic [SENS_W-1:0] x);
    sat = (x > SENS_MAX) ? SENS_MAX : x;
  endfunction

  function automatic logic signed [SPD_W-1:0] clamp_drive(
    input logic signed [CORR_W-1:0] v
  );
    if (v > CORR_W'(DRIVE_MAX))
      clamp_drive = DRIVE_MAX;
    else if (v < CORR_W'(DRIVE_MIN))
      clamp_drive = DRIVE_MIN;
    else
      clamp_drive = v[SPD_W-1:0];
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign div_start = (state == S_LOAD);

  always_comb begin
    unique case (paddr[2])
      REG_TARGET: prdata = {{(DATA_W-SPD_W){1'b0}}, tgt};
      REG_WINDOW: prdata = {{(DATA_W-1){1'b0}}, window};
      default:    prdata = '0;
    endcase
  end

  // centroid operands: num = 1000 * (b + 2c + 3d + 4e), with e only in window mode
  always_comb begin
    wsum = WSUM_W'(s_b) + WSUM_W'({s_c, 1'b0}) + WSUM_W'(s_d) + WSUM_W'({s_d, 1'b0})
         + (window ? WSUM_W'({s_e, 2'b0}) : '0);
    num  = NUM_W'(wsum) * WEIGHT;
    sum  = SUM_W'(s_b) + SUM_W'(s_c) + SUM_W'(s_d)
         + (window ? (SUM_W'(s_a) + SUM_W'(s_e)) : '0);
  end

  // speed ramp
  always_comb begin
    tdiff     = t_in - last_ramp;
    spd_delta = {tgt[SPD_W-1], tgt} - {cur_speed[SPD_W-1], cur_speed};
    if (spd_delta > RAMP_STEP)
      spd_step = RAMP_STEP;
    else if (spd_delta < -RAMP_STEP)
      spd_step = -RAMP_STEP;
    else
      spd_step = spd_delta;
    cur_speed_next = cur_speed + spd_step[SPD_W-1:0];
  end

  // error and derivative
  always_comb begin
    pos  = nl_r ? CENTER_POS : div_quo;
    err  = $signed({1'b0, pos}) - $signed({1'b0, CENTER_POS});
    dval = err - {prev_err[ERR_W-1], prev_err};
  end

  // truncating divisions by 10, 25 and 3 through reciprocals
  always_comb begin
    err_abs = err_r[D_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
    d_abs   = d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r);
    recip_e = (cur_speed > SPD_MID) ? RECIP_10 : RECIP_25;
    pe      = PE_W'(err_abs) * PE_W'(recip_e);
    pd      = PD_W'(d_abs) * PD_W'(RECIP_3);
  end

  // gain selection
  always_comb begin
    e16  = CORR_W'(e_div);
    d16  = CORR_W'(d_r);
    dd16 = CORR_W'(d_div);
    d5   = (d16 <<< 2) + d16;
    fh   = d5 >>> 1;
  end

  always_comb begin
    spd16      = CORR_W'(cur_speed);
    lsum       = spd16 + corr;
    rsum       = spd16 - corr;
    left_next  = clamp_drive(lsum);
    right_next = clamp_drive(rsum);
  end

  lfpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (sum),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      tgt       <= SPD_RESET;
      window    <= 1'b0;
      cur_speed <= SPD_RESET;
      last_ramp <= '0;
      prev_err  <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_TARGET: tgt    <= pwdata[SPD_W-1:0];
          REG_WINDOW: window <= pwdata[0];
          default:    ;
        endcase
      end
      // in the output state a taken word is replaced by the next one below
      if (out_valid && !out_stall && state != S_OUT)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept)
            state <= S_LOAD;
        end
        S_LOAD: begin
          if (tdiff >= RAMP_PERIOD) begin
            last_ramp <= t_in;
            cur_speed <= cur_speed_next;
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done)
            state <= S_PD1;
        end
        S_PD1: begin
          prev_err <= err[ERR_W-1:0];
          state    <= S_PD2;
        end
        S_PD2: state <= S_PD3;
        S_PD3: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      t_in <= time_ms;
      s_a  <= sat(sensor_a);
      s_b  <= sat(sensor_b);
      s_c  <= sat(sensor_c);
      s_d  <= sat(sensor_d);
      s_e  <= sat(sensor_e);
    end
    if (state == S_LOAD)
      nl_r <= (sum == '0);
    if (state == S_PD1) begin
      err_r <= err;
      d_r   <= dval;
    end
    if (state == S_PD2) begin
      e_div <= err_r[D_W-1] ? -$signed(pe[PE_W-1:RECIP_SH])
                            : $signed(pe[PE_W-1:RECIP_SH]);
      d_div <= d_r[D_W-1] ? -$signed(pd[PD_W-1:RECIP_SH])
                          : $signed(pd[PD_W-1:RECIP_SH]);
    end
    if (state == S_PD3) begin
      priority if (cur_speed > SPD_HI)
        corr <= e16 + fh;
      else if (cur_speed > SPD_MID)
        corr <= e16 + d16;
      else
        corr <= e16 + dd16;
    end
    if (state == S_OUT && out_free) begin
      left_drive  <= left_next;
      right_drive <= right_next;
      no_line     <= nl_r;
    end
  end

  // drives never leave the saturation window
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive <= DRIVE_MAX && left_drive >= DRIVE_MIN &&
                   right_drive <= DRIVE_MAX && right_drive >= DRIVE_MIN))
    else $error("drive outside saturation window");

  // speed moves by at most one ramp step per cycle
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      (($signed({cur_speed[SPD_W-1], cur_speed}) -
        $signed({$past(cur_speed[SPD_W-1]), $past(cur_speed)})) <= RAMP_STEP &&
       ($signed({cur_speed[SPD_W-1], cur_speed}) -
        $signed({$past(cur_speed[SPD_W-1]), $past(cur_speed)})) >= -RAMP_STEP))
    else $error("speed jumped by more than one ramp step");

  // divider finishes only while the controller waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside divide state");

  // ramp time only changes while a frame is loaded (speed is updated there too, but not checked here)
  assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |=> $stable(last_ramp))
    else $error("ramp time changed outside load state");

endmodule

`default_nettype wire

@@ verif/lfpd_drive_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfpd_drive_checker
// watches the config port and both word channels of the pd drive block,
// predicts each drive word from the sensor frames and compares in order
// ----------------------------------------------------------------------------

module lfpd_drive_checker (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire                               pready,
  input  wire  [lfpd_pkg::ADDR_W-1:0]       paddr,
  input  wire  [lfpd_pkg::DATA_W-1:0]       pwdata,
  input  wire                               in_valid,
  input  wire                               in_stall,
  input  wire  [lfpd_pkg::TIME_W-1:0]       time_ms,
  input  wire  [lfpd_pkg::SENS_W-1:0]       sensor_a,
  input  wire  [lfpd_pkg::SENS_W-1:0]       sensor_b,
  input  wire  [lfpd_pkg::SENS_W-1:0]       sensor_c,
  input  wire  [lfpd_pkg::SENS_W-1:0]       sensor_d,
  input  wire  [lfpd_pkg::SENS_W-1:0]       sensor_e,
  input  wire                               out_valid,
  input  wire                               out_stall,
  input  wire signed [lfpd_pkg::SPD_W-1:0]  left_drive,
  input  wire signed [lfpd_pkg::SPD_W-1:0]  right_drive,
  input  wire                               no_line,
  output int                                fail_count,
  output int                                in_flight,
  output int                                words_checked,
  output int                                dark_frames,
  output int                                fast_frames
);

  typedef struct packed {
    logic signed [lfpd_pkg::SPD_W-1:0] left;
    logic signed [lfpd_pkg::SPD_W-1:0] right;
    logic                              dark;
  } drive_word_t;

  // mirrored registers and steering state
  int                          target_spd;
  logic                        wide_window;
  int                          cur_speed;
  logic [lfpd_pkg::TIME_W-1:0] last_ramp;
  int                          prev_err;

  drive_word_t drive_q[$];
  int fails, checked, dark_n, fast_n;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // floor of x/2 for either sign
  function automatic int half_down(int x);
    if (x >= 0) return x / 2;
    return -((1 - x) / 2);
  endfunction

  function automatic int sat_sample(logic [lfpd_pkg::SENS_W-1:0] s);
    return (s > lfpd_pkg::SENS_MAX) ? int'(lfpd_pkg::SENS_MAX) : int'(s);
  endfunction

  function automatic drive_word_t steer_frame(logic [lfpd_pkg::TIME_W-1:0] t,
                                              logic [lfpd_pkg::SENS_W-1:0] a,
                                              logic [lfpd_pkg::SENS_W-1:0] b,
                                              logic [lfpd_pkg::SENS_W-1:0] c,
                                              logic [lfpd_pkg::SENS_W-1:0] d,
                                              logic [lfpd_pkg::SENS_W-1:0] e);
    int sa, sb, sc, sd, se, wsum, wnum, pos, err, dlt, corr, lft, rgt;
    logic [lfpd_pkg::TIME_W-1:0] dt;
    drive_word_t w;
    sa = sat_sample(a);
    sb = sat_sample(b);
    sc = sat_sample(c);
    sd = sat_sample(d);
    se = sat_sample(e);
    wsum = sb + sc + sd;
    wnum = sb * 1000 + sc * 2000 + sd * 3000;
    if (wide_window) begin
      wsum += sa + se;
      wnum += se * 4000;
    end
    w.dark = (wsum == 0);
    pos = w.dark ? 2000 : wnum / wsum;
    // elapsed time wraps modulo 2^32
    dt = t - last_ramp;
    if (dt >= 3) begin
      last_ramp = t;
      cur_speed += clip(target_spd - cur_speed, -3, 3);
    end
    err = pos - 2000;
    dlt = err - prev_err;
    prev_err = err;
    if (cur_speed > 150) begin
      corr = err / 10 + half_down(5 * dlt);
      fast_n++;
    end else if (cur_speed > 100) begin
      corr = err / 10 + dlt;
    end else begin
      corr = err / 25 + dlt / 3;
    end
    lft = clip(cur_speed + corr, -250, 250);
    rgt = clip(cur_speed - corr, -250, 250);
    w.left = lft[lfpd_pkg::SPD_W-1:0];
    w.right = rgt[lfpd_pkg::SPD_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin : track
    drive_word_t want;
    if (rst) begin
      target_spd = lfpd_pkg::SPD_RESET;
      wide_window = 1'b0;
      cur_speed = lfpd_pkg::SPD_RESET;
      last_ramp = '0;
      prev_err = 0;
      drive_q.delete();
      fails = 0;
      checked = 0;
      dark_n = 0;
      fast_n = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == lfpd_pkg::REG_TARGET) target_spd = int'($signed(pwdata[8:0]));
        else wide_window = pwdata[0];
      end
      if (in_valid && !in_stall)
        drive_q.push_back(steer_frame(time_ms, sensor_a, sensor_b, sensor_c, sensor_d,
                                      sensor_e));
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected drive word left=%0d right=%0d no_line=%0b",
                     $time, left_drive, right_drive, no_line);
        end else begin
          want = drive_q.pop_front();
          checked++;
          if (want.dark) dark_n++;
          if (want.left !== left_drive || want.right !== right_drive ||
              want.dark !== no_line) begin
            fails++;
            if (fails <= 10)
              $display("%0t: word %0d mismatch: ", $time, checked,
                       "expected left=%0d right=%0d no_line=%0b, ",
                       want.left, want.right, want.dark,
                       "got left=%0d right=%0d no_line=%0b",
                       left_drive, right_drive, no_line);
          end
        end
      end
    end
    fail_count <= fails;
    in_flight <= drive_q.size();
    words_checked <= checked;
    dark_frames <= dark_n;
    fast_frames <= fast_n;
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// testbench for line_follow_pd_drive: directed and random sensor frames
// across several speed targets and both window modes, with random input gaps,
// random output stalls and one long output hold; drive words are checked by the
// checker module running beside the block
// ----------------------------------------------------------------------------

module tb;

  localparam int QUIET_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [lfpd_pkg::ADDR_W-1:0]   paddr = '0;
  logic [lfpd_pkg::DATA_W-1:0]   pwdata = '0;
  wire  [lfpd_pkg::DATA_W-1:0]   prdata;
  wire                           pready;

  logic                          in_valid = 1'b0;
  wire                           in_stall;
  logic [lfpd_pkg::TIME_W-1:0]   time_ms = '0;
  logic [lfpd_pkg::SENS_W-1:0]   sensor_a = '0;
  logic [lfpd_pkg::SENS_W-1:0]   sensor_b = '0;
  logic [lfpd_pkg::SENS_W-1:0]   sensor_c = '0;
  logic [lfpd_pkg::SENS_W-1:0]   sensor_d = '0;
  logic [lfpd_pkg::SENS_W-1:0]   sensor_e = '0;

  wire                           out_valid;
  logic                          out_stall = 1'b0;
  wire signed [lfpd_pkg::SPD_W-1:0] left_drive;
  wire signed [lfpd_pkg::SPD_W-1:0] right_drive;
  wire                           no_line;

  int fail_count, in_flight, words_checked, dark_frames, fast_frames;

  logic calm = 1'b0;
  logic hold_request = 1'b0;
  logic held = 1'b0;
  int   hold_left = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  int   frames_sent = 0;
  logic [lfpd_pkg::TIME_W-1:0] clock_ms = '0;

  line_follow_pd_drive u_top (.*);

  lfpd_drive_checker u_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // output side: random stall bursts, one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_request && !held) begin
      held <= 1'b1;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
    end else begin
      burst_left <= $urandom_range(0, 6);
      out_stall <= ($urandom_range(0, 9) < 4);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(input logic [lfpd_pkg::ADDR_W-1:0] addr,
                           input logic [lfpd_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_frame(input logic [lfpd_pkg::TIME_W-1:0] t,
                            input logic [lfpd_pkg::SENS_W-1:0] a,
                            input logic [lfpd_pkg::SENS_W-1:0] b,
                            input logic [lfpd_pkg::SENS_W-1:0] c,
                            input logic [lfpd_pkg::SENS_W-1:0] d,
                            input logic [lfpd_pkg::SENS_W-1:0] e);
    int gap;
    in_valid <= 1'b1;
    time_ms <= t;
    sensor_a <= a;
    sensor_b <= b;
    sensor_c <= c;
    sensor_d <= d;
    sensor_e <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every word in flight come out before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic random_frame();
    logic [lfpd_pkg::SENS_W-1:0] s[5];
    int kind, peak, r, i;
    kind = $urandom_range(0, 99);
    peak = $urandom_range(0, 4);
    for (i = 0; i < 5; i++) begin
      if (kind < 55) begin
        // line under one sensor with some spill onto its neighbors
        if (i == peak) s[i] = 10'($urandom_range(600, 1000));
        else if (i == peak - 1 || i == peak + 1) s[i] = 10'($urandom_range(0, 500));
        else s[i] = 10'($urandom_range(0, 60));
      end else if (kind < 63) begin
        s[i] = '0;
      end else if (kind < 80) begin
        s[i] = 10'($urandom_range(0, 1023));
      end else if (kind < 90) begin
        s[i] = 10'($urandom_range(0, 7));
      end else begin
        s[i] = 10'($urandom_range(900, 1023));
      end
    end
    // dark middle with the outer sensors lit
    if (kind >= 55 && kind < 63 && $urandom_range(0, 1) == 1) begin
      s[0] = 10'($urandom_range(0, 1023));
      s[4] = 10'($urandom_range(0, 1023));
    end
    r = $urandom_range(0, 99);
    if (r < 75) clock_ms += $urandom_range(3, 6);
    else if (r < 95) clock_ms += $urandom_range(0, 2);
    else clock_ms = $urandom();
    push_frame(clock_ms, s[0], s[1], s[2], s[3], s[4]);
  endtask

  task automatic run_phase(input int target, input logic wide, input int count,
                           input logic squeeze);
    int k;
    drain();
    reg_write({lfpd_pkg::REG_TARGET, 2'b00}, 32'(target));
    reg_write({lfpd_pkg::REG_WINDOW, 2'b00}, {31'b0, wide});
    if (squeeze) hold_request <= 1'b1;
    for (k = 0; k < count; k++) random_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: target 50, middle three sensors
    push_frame(32'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    push_frame(32'd1, 10'd1000, 10'd0, 10'd0, 10'd0, 10'd1000);
    push_frame(32'd2, 10'd0, 10'd0, 10'd1000, 10'd0, 10'd0);
    push_frame(32'd3, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd0);
    push_frame(32'd5, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd0);
    push_frame(32'd6, 10'd0, 10'd1, 10'd0, 10'd2, 10'd0);
    push_frame(32'd7, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    push_frame(32'hFFFF_FFFF, 10'd0, 10'd500, 10'd250, 10'd0, 10'd0);
    push_frame(32'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd7);
    push_frame(32'd2, 10'd0, 10'd3, 10'd1, 10'd0, 10'd0);
    drain();
    reg_write({lfpd_pkg::REG_TARGET, 2'b00}, 32'd255);
    reg_write({lfpd_pkg::REG_WINDOW, 2'b00}, 32'd1);
    // all five sensors
    push_frame(32'd3, 10'd1000, 10'd0, 10'd0, 10'd0, 10'd0);
    push_frame(32'd4, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1000);
    push_frame(32'd5, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    push_frame(32'd9, 10'd1000, 10'd0, 10'd0, 10'd0, 10'd1000);
    push_frame(32'd13, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    push_frame(32'd17, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023);
    push_frame(32'd21, 10'd1, 10'd0, 10'd0, 10'd0, 10'd2);
    clock_ms = 32'd21;

    run_phase(255, 1'b1, 70, 1'b0);
    run_phase(120, 1'b0, 40, 1'b0);
    run_phase(-256, 1'b1, 140, 1'b1);
    run_phase(-250, 1'b0, 40, 1'b0);
    run_phase(250, 1'b1, 90, 1'b0);
    run_phase(0, 1'b0, 40, 1'b0);
    calm <= 1'b1;
    run_phase(160, 1'b1, 60, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    $display("%0d sensor frames sent, %0d drive words checked, ",
             frames_sent, words_checked,
             "%0d with no line, %0d in the top gain band", dark_frames, fast_frames);
    $display("targets from -256 to 255 in both window modes, random stalls and one long output hold");
    if (fail_count == 0 && in_flight == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lfpd_pkg.sv
hw/rtl/lfpd_div.sv
hw/rtl/line_follow_pd_drive.sv
verif/lfpd_drive_checker.sv
verif/tb.sv
